// ===== rtl/fdrs_pkg.sv =====
`default_nettype none

package fdrs_pkg;

    localparam int FDRS_FRAME_WIDTH  = 160;
    localparam int FDRS_FRAME_HEIGHT = 80;
    localparam int FDRS_QUEUE_DEPTH  = 4;

    localparam int FDRS_PIXEL_W = 16;
    localparam int FDRS_ROW_W   = 7;

    localparam logic FDRS_CMD_PIXEL      = 1'b0;
    localparam logic FDRS_CMD_INVALIDATE = 1'b1;

    // one completed row, as seen by the strip builder
    typedef struct packed {
        logic                  dirty;
        logic                  frame_end;
        logic                  full;
        logic [FDRS_ROW_W-1:0] row;
    } t_row_evt;

endpackage

`default_nettype wire

// ===== rtl/fdrs_front.sv =====
`default_nettype none

module fdrs_front import fdrs_pkg::*; #(
    parameter int FRAME_WIDTH  = FDRS_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = FDRS_FRAME_HEIGHT,
    parameter int Q_DEPTH      = FDRS_QUEUE_DEPTH,
    localparam int CNT_W       = $clog2(Q_DEPTH + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_cmd,
    input  wire logic [FDRS_PIXEL_W-1:0] i_pixel,
    input  wire logic [CNT_W-1:0]        i_q_count,
    output logic                         o_push,
    output t_row_evt                     o_evt
);

    localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FDRS_PIXEL_W-1:0] mem [DEPTH];

    logic                    r_force_full;
    logic                    r_frame_full;
    logic [COL_W-1:0]        r_col;
    logic [FDRS_ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]       r_addr;
    logic                    r_s1_valid;
    logic                    r_row_differs;
    logic [FDRS_PIXEL_W-1:0] r_s1_px;
    logic [FDRS_PIXEL_W-1:0] r_s1_rd;
    logic                    r_s1_row_end;
    logic                    r_s1_frame_end;
    logic                    r_s1_full;
    logic [FDRS_ROW_W-1:0]   r_s1_row;

    logic acc;
    logic acc_px;
    logic first;
    logic row_end;
    logic frame_end;
    logic pending;
    logic differs;

    assign acc       = i_valid && !o_stall;
    assign acc_px    = acc && (i_cmd == FDRS_CMD_PIXEL);
    assign first     = (r_col == '0) && (r_row == '0);
    assign row_end   = (r_col == COL_W'(FRAME_WIDTH - 1));
    assign frame_end = row_end && (r_row == FDRS_ROW_W'(FRAME_HEIGHT - 1));
    assign pending   = r_s1_valid && r_s1_row_end;
    assign o_stall   = (int'(i_q_count) + int'(pending)) >= Q_DEPTH;

    assign differs         = (r_s1_rd != r_s1_px);
    assign o_push          = pending;
    assign o_evt.dirty     = r_row_differs || differs;
    assign o_evt.frame_end = r_s1_frame_end;
    assign o_evt.full      = r_s1_full;
    assign o_evt.row       = r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_full  <= 1'b1;
            r_frame_full  <= 1'b0;
            r_col         <= '0;
            r_row         <= '0;
            r_addr        <= '0;
            r_s1_valid    <= 1'b0;
            r_row_differs <= 1'b0;
        end else begin
            r_s1_valid <= acc_px;
            if (acc && (i_cmd == FDRS_CMD_INVALIDATE)) begin
                r_force_full <= 1'b1;
            end
            if (acc_px) begin
                if (first) begin
                    r_frame_full <= r_force_full;
                    r_force_full <= 1'b0;
                end
                if (frame_end) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_addr <= '0;
                end else if (row_end) begin
                    r_col  <= '0;
                    r_row  <= r_row + 1'b1;
                    r_addr <= r_addr + 1'b1;
                end else begin
                    r_col  <= r_col + 1'b1;
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (r_s1_valid) begin
                r_row_differs <= r_s1_row_end ? 1'b0 : (r_row_differs || differs);
            end
        end
    end

    // read-first frame store, one access per pixel
    always_ff @(posedge i_clk) begin
        if (acc_px) begin
            r_s1_rd      <= mem[r_addr];
            mem[r_addr]  <= i_pixel;
            r_s1_px        <= i_pixel;
            r_s1_row_end   <= row_end;
            r_s1_frame_end <= frame_end;
            r_s1_full      <= first ? r_force_full : r_frame_full;
            r_s1_row       <= r_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fdrs_queue.sv =====
`default_nettype none

module fdrs_queue import fdrs_pkg::*; #(
    parameter int Q_DEPTH = FDRS_QUEUE_DEPTH,
    localparam int CNT_W  = $clog2(Q_DEPTH + 1)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_row_evt   i_evt,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_row_evt        o_evt,
    output logic [CNT_W-1:0] o_count
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_row_evt         r_buf [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_evt   = r_buf[r_rd];
    assign o_count = r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_evt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fdrs_back.sv =====
`default_nettype none

module fdrs_back import fdrs_pkg::*; #(
    parameter int FRAME_HEIGHT = FDRS_FRAME_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_row_evt              i_evt,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [FDRS_ROW_W-1:0]      o_region_top,
    output logic [FDRS_ROW_W-1:0]      o_region_rows,
    output logic                       o_full_screen
);

    logic                  r_open;
    logic [FDRS_ROW_W-1:0] r_start;
    logic                  r_out_valid;
    logic [FDRS_ROW_W-1:0] r_top;
    logic [FDRS_ROW_W-1:0] r_rows;
    logic                  r_full;

    logic                  out_free;
    logic [FDRS_ROW_W-1:0] start;
    logic                  res_valid;
    logic [FDRS_ROW_W-1:0] res_top;
    logic [FDRS_ROW_W-1:0] res_rows;
    logic                  res_full;
    logic                  n_open;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_q_valid && out_free;
    assign start    = r_open ? r_start : i_evt.row;

    always_comb begin
        res_valid = 1'b0;
        res_top   = start;
        res_rows  = i_evt.row + 1'b1 - start;
        res_full  = 1'b0;
        n_open    = r_open;
        if (i_evt.full) begin
            if (i_evt.frame_end) begin
                res_valid = 1'b1;
                res_top   = '0;
                res_rows  = FDRS_ROW_W'(FRAME_HEIGHT);
                res_full  = 1'b1;
            end
        end else if (i_evt.dirty) begin
            n_open = 1'b1;
            if (i_evt.frame_end) begin
                res_valid = 1'b1;
            end
        end else if (r_open) begin
            res_valid = 1'b1;
            res_rows  = i_evt.row - r_start;
            n_open    = 1'b0;
        end
        if (i_evt.frame_end) begin
            n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_open <= n_open;
            end
            if (out_free) begin
                r_out_valid <= o_pop && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start <= start;
        end
        if (o_pop && res_valid) begin
            r_top  <= res_top;
            r_rows <= res_rows;
            r_full <= res_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_region_top  = r_top;
    assign o_region_rows = r_rows;
    assign o_full_screen = r_full;

endmodule

`default_nettype wire

// ===== rtl/framebuffer_dirty_row_strips.sv =====
// framebuffer_dirty_row_strips
// input channel (i_valid / o_stall): one transaction per pixel in raster order,
// i_cmd low with i_pixel, or i_cmd high to force the next frame out whole.
// the invalidate is sampled when the first pixel of a frame is taken.
// output channel (o_valid / i_stall): one transaction per dirty strip, giving
// top row and row count, or one full-screen region for a forced frame.
// throughput: one transaction per cycle while o_stall is low, set by the single
// read-first port of the frame store (one read and one write per pixel).
// a strip closed by a pixel passes the stage-one register, the row queue and
// the output register, waiting only while older rows are queued or the output is busy.
// completed rows pass through a four-entry queue to the strip builder; when
// the receiver stalls, the output register holds, the queue fills and o_stall
// rises only once the queue has no room for another row end.
// reset clears the counters, the queue and the output valid and sets the
// force-full flag, so the first frame is sent whole; the frame store is not
// cleared, no pass is needed.
`default_nettype none

module framebuffer_dirty_row_strips import fdrs_pkg::*; #(
    parameter int FRAME_WIDTH  = FDRS_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = FDRS_FRAME_HEIGHT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_cmd,
    input  wire logic [FDRS_PIXEL_W-1:0] i_pixel,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [FDRS_ROW_W-1:0]        o_region_top,
    output logic [FDRS_ROW_W-1:0]        o_region_rows,
    output logic                         o_full_screen
);

    localparam int CNT_W = $clog2(FDRS_QUEUE_DEPTH + 1);

    logic             push;
    logic             pop;
    logic             q_valid;
    t_row_evt         push_evt;
    t_row_evt         q_evt;
    logic [CNT_W-1:0] q_count;

    fdrs_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .Q_DEPTH      (FDRS_QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_pixel   (i_pixel),
        .i_q_count (q_count),
        .o_push    (push),
        .o_evt     (push_evt)
    );

    fdrs_queue #(
        .Q_DEPTH (FDRS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_evt   (q_evt),
        .o_count (q_count)
    );

    fdrs_back #(
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_evt         (q_evt),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_region_top  (o_region_top),
        .o_region_rows (o_region_rows),
        .o_full_screen (o_full_screen)
    );

endmodule

`default_nettype wire

// ===== rtl/fdrs_checker.sv =====
`default_nettype none

module fdrs_checker import fdrs_pkg::*; #(
    parameter int FRAME_HEIGHT = FDRS_FRAME_HEIGHT
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [FDRS_ROW_W-1:0] o_region_top,
    input wire logic [FDRS_ROW_W-1:0] o_region_rows,
    input wire logic                  o_full_screen
);

    // stalled output transaction holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_region_top)
            && $stable(o_region_rows) && $stable(o_full_screen))
        else $error("stalled output transaction changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_screen |->
            o_region_top == '0 && o_region_rows == FDRS_ROW_W'(FRAME_HEIGHT))
        else $error("full-screen region is not the whole frame");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_region_rows != '0
            && (int'(o_region_top) + int'(o_region_rows)) <= FRAME_HEIGHT)
        else $error("strip outside the frame");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind framebuffer_dirty_row_strips fdrs_checker #(
    .FRAME_HEIGHT (FRAME_HEIGHT)
) u_fdrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_region_top  (o_region_top),
    .o_region_rows (o_region_rows),
    .o_full_screen (o_full_screen)
);

`default_nettype wire

// ===== verif/dirty_strip_checker.sv =====
`timescale 1ns / 100ps

module dirty_strip_checker import fdrs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic                    i_cmd,
    input  wire logic [FDRS_PIXEL_W-1:0] i_pixel,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic [FDRS_ROW_W-1:0]   i_region_top,
    input  wire logic [FDRS_ROW_W-1:0]   i_region_rows,
    input  wire logic                    i_full_screen,
    output int                           o_fail_count = 0,
    output int                           o_pending = 0
);

    localparam int PIXELS = FDRS_FRAME_WIDTH * FDRS_FRAME_HEIGHT;

    typedef struct packed {
        logic [FDRS_ROW_W-1:0] top;
        logic [FDRS_ROW_W-1:0] rows;
        logic                  full;
    } t_strip;

    t_strip expected_strips [$];

    logic [FDRS_PIXEL_W-1:0] frame_copy [PIXELS];
    logic                    whole_next;
    logic                    whole_frame;
    int                      col;
    int                      row;
    logic                    row_dirty;
    logic                    strip_active;
    int                      strip_top;
    int                      fail_total = 0;

    initial begin
        for (int i = 0; i < PIXELS; i++) begin
            frame_copy[i] = '0;
        end
    end

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic push_strip(input int top, input int rows, input logic full);
        t_strip s;
        s.top  = FDRS_ROW_W'(top);
        s.rows = FDRS_ROW_W'(rows);
        s.full = full;
        expected_strips.push_back(s);
    endtask

    task automatic track_item(input logic cmd, input logic [FDRS_PIXEL_W-1:0] px);
        int   addr;
        logic differs;
        logic row_end;
        logic frame_end;
        logic dirty;
        if (cmd == FDRS_CMD_INVALIDATE) begin
            whole_next = 1'b1;
        end else begin
            if (col == 0 && row == 0) begin
                whole_frame  = whole_next;
                whole_next   = 1'b0;
                strip_active = 1'b0;
                row_dirty    = 1'b0;
            end
            addr = row * FDRS_FRAME_WIDTH + col;
            differs = (frame_copy[addr] != px);
            frame_copy[addr] = px;
            row_end   = (col == FDRS_FRAME_WIDTH - 1);
            frame_end = row_end && (row == FDRS_FRAME_HEIGHT - 1);
            if (!row_end) begin
                row_dirty = row_dirty | differs;
                col++;
            end else begin
                dirty     = row_dirty | differs;
                row_dirty = 1'b0;
                col       = 0;
                if (whole_frame) begin
                    if (frame_end) begin
                        push_strip(0, FDRS_FRAME_HEIGHT, 1'b1);
                    end
                end else if (dirty) begin
                    if (!strip_active) begin
                        strip_active = 1'b1;
                        strip_top    = row;
                    end
                    if (frame_end) begin
                        push_strip(strip_top, row + 1 - strip_top, 1'b0);
                        strip_active = 1'b0;
                    end
                end else if (strip_active) begin
                    push_strip(strip_top, row - strip_top, 1'b0);
                    strip_active = 1'b0;
                end
                if (frame_end) begin
                    row          = 0;
                    strip_active = 1'b0;
                    whole_frame  = 1'b0;
                end else begin
                    row++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_strip seen;
        t_strip want;
        if (!i_rst_n) begin
            whole_next   = 1'b1;
            whole_frame  = 1'b0;
            col          = 0;
            row          = 0;
            row_dirty    = 1'b0;
            strip_active = 1'b0;
            strip_top    = 0;
            expected_strips.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                track_item(i_cmd, i_pixel);
            end
            if (i_out_valid && !i_out_stall) begin
                seen.top  = i_region_top;
                seen.rows = i_region_rows;
                seen.full = i_full_screen;
                if (expected_strips.size() == 0) begin
                    note_failure($sformatf("unexpected region: top %0d rows %0d full %0b",
                        seen.top, seen.rows, seen.full));
                end else begin
                    want = expected_strips.pop_front();
                    if (seen.top != want.top || seen.rows != want.rows
                            || seen.full != want.full) begin
                        note_failure($sformatf({"region mismatch: expected top %0d ",
                            "rows %0d full %0b, got top %0d rows %0d full %0b"},
                            want.top, want.rows, want.full,
                            seen.top, seen.rows, seen.full));
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_strips.size();
    end

endmodule

// ===== verif/framebuffer_dirty_row_strips_test.sv =====
`timescale 1ns / 100ps

module framebuffer_dirty_row_strips_test;
    import fdrs_pkg::*;

    localparam int PIXELS         = FDRS_FRAME_WIDTH * FDRS_FRAME_HEIGHT;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum logic [1:0] {
        STYLE_NOISE,
        STYLE_ROWS,
        STYLE_ALTERNATE
    } t_frame_style;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    i_cmd   = FDRS_CMD_PIXEL;
    logic [FDRS_PIXEL_W-1:0] i_pixel = '0;
    logic                    i_stall = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [FDRS_ROW_W-1:0]   o_region_top;
    logic [FDRS_ROW_W-1:0]   o_region_rows;
    logic                    o_full_screen;

    int                      fail_count;
    int                      pending;
    logic                    calm      = 1'b0;
    logic                    stim_done = 1'b0;
    int                      quiet_cycles = 0;
    int                      next_pos = 0;
    logic [FDRS_PIXEL_W-1:0] last_sent [PIXELS];

    framebuffer_dirty_row_strips uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_region_top  (o_region_top),
        .o_region_rows (o_region_rows),
        .o_full_screen (o_full_screen)
    );

    dirty_strip_checker strip_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_pixel       (i_pixel),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_region_top  (o_region_top),
        .i_region_rows (o_region_rows),
        .i_full_screen (o_full_screen),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 20);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (stim_done && pending == 0) || (i_valid && !o_stall)
                || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [FDRS_PIXEL_W-1:0] px);
        while (!calm && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [FDRS_PIXEL_W-1:0] px);
        last_sent[next_pos] = px;
        next_pos = (next_pos + 1) % PIXELS;
        send_item(FDRS_CMD_PIXEL, px);
    endtask

    // runs the current frame to its end; an invalidate goes in before pixel inval_pos
    task automatic finish_frame(input t_frame_style style, input int dirty_pct,
                                input int inval_pos);
        int                      col;
        int                      row;
        int                      spot_col = 0;
        logic                    spread = 1'b0;
        logic                    row_dirty = 1'b0;
        logic [FDRS_PIXEL_W-1:0] px;
        do begin
            col = next_pos % FDRS_FRAME_WIDTH;
            row = next_pos / FDRS_FRAME_WIDTH;
            if (next_pos == inval_pos) begin
                send_item(FDRS_CMD_INVALIDATE, FDRS_PIXEL_W'($urandom));
            end
            if (col == 0) begin
                if (style == STYLE_ALTERNATE) begin
                    row_dirty = (row % 2 == 0);
                end else begin
                    row_dirty = ($urandom_range(99) < dirty_pct);
                end
                case ($urandom_range(3))
                    0: spot_col = 0;
                    1: spot_col = FDRS_FRAME_WIDTH - 1;
                    default: spot_col = $urandom_range(FDRS_FRAME_WIDTH - 1);
                endcase
                spread = ($urandom_range(3) == 0);
            end
            if (style == STYLE_NOISE) begin
                px = FDRS_PIXEL_W'($urandom);
            end else if (row_dirty && (col == spot_col
                    || (spread && $urandom_range(7) == 0))) begin
                px = last_sent[next_pos] ^ FDRS_PIXEL_W'($urandom_range(16'hFFFF, 1));
            end else begin
                px = last_sent[next_pos];
            end
            send_pixel(px);
        end while (next_pos != 0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // invalidates ahead of the first frame and in the middle of it
        send_item(FDRS_CMD_INVALIDATE, '1);
        send_item(FDRS_CMD_INVALIDATE, '0);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        send_item(FDRS_CMD_INVALIDATE, 16'h8001);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        finish_frame(STYLE_NOISE, 0, -1);
        finish_frame(STYLE_NOISE, 0, -1);

        calm = 1'b1;
        finish_frame(STYLE_NOISE, 0, -1);
        calm = 1'b0;

        finish_frame(STYLE_ROWS, 0, -1);
        finish_frame(STYLE_ALTERNATE, 0, -1);
        finish_frame(STYLE_ROWS, 50, -1);
        finish_frame(STYLE_ROWS, 50, 0);
        finish_frame(STYLE_ROWS, 30, $urandom_range(PIXELS - 1, 1));
        finish_frame(STYLE_ROWS, 70, -1);
        finish_frame(STYLE_ROWS, 60, -1);

        i_valid <= 1'b0;
        stim_done = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
